// File: rtl/adaptive_two_way_signal_timer_unit_defines.svh
// Assertion macros used by the signal timer core.
`ifndef ADAPTIVE_TWO_WAY_SIGNAL_TIMER_UNIT_DEFINES_SVH
`define ADAPTIVE_TWO_WAY_SIGNAL_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ATWST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
// Condition must never be true outside reset.
`define ATWST_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`else
`define ATWST_ASSERT(lbl, clk, rstn, prop, msg)
`define ATWST_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: rtl/atwst_pkg.sv
// Types and constants of the adaptive two-way signal timer.
`default_nettype none

package atwst_pkg;

  // Queue ceiling; counts are 8 bits wide, so the cap never exceeds 255
  localparam int unsigned MaxQueue = 255;
  localparam logic [7:0]  QueueCap = 8'((MaxQueue < 255) ? MaxQueue : 255);

  // Load is queue * 100 against percent * green
  localparam int unsigned LoadScale = 100;
  localparam int unsigned LoadW     = 15;
  localparam int unsigned HiThrW    = 16;
  localparam int unsigned LoThrW    = 15;

  // Register reset values
  localparam logic [7:0] StdGreenRst = 8'd20;
  localparam logic [7:0] MaxGreenRst = 8'd255;
  localparam logic [6:0] HighPctRst  = 7'd70;
  localparam logic [6:0] LowPctRst   = 7'd50;

  // APB map: one 32-bit register per word
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    CfgStdGreen = 2'd0,
    CfgMaxGreen = 2'd1,
    CfgHighPct  = 2'd2,
    CfgLowPct   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] std_green;
    logic [7:0] max_green;
    logic [6:0] high_pct;
    logic [6:0] low_pct;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/atwst_intf.sv
// Valid/ready channel interfaces for arrivals and timer results.
`default_nettype none

interface atwst_in_if;
  logic valid;
  logic ready;
  logic arrive_a;
  logic arrive_b;

  modport source (output valid, output arrive_a, output arrive_b, input ready);
  modport sink   (input valid, input arrive_a, input arrive_b, output ready);
endinterface

interface atwst_out_if;
  logic       valid;
  logic       ready;
  logic       side_now;
  logic [7:0] remaining;
  logic       switched;
  logic [7:0] queue_a;
  logic [7:0] queue_b;
  logic [7:0] green_a;
  logic [7:0] green_b;

  modport source (output valid, output side_now, output remaining, output switched,
                  output queue_a, output queue_b, output green_a, output green_b,
                  input ready);
  modport sink   (input valid, input side_now, input remaining, input switched,
                  input queue_a, input queue_b, input green_a, input green_b,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/atwst_cfg.sv
// APB register file holding the timer configuration.
`default_nettype none

module atwst_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [atwst_pkg::AddrW-1:0] paddr,
  input  wire logic [atwst_pkg::DataW-1:0] pwdata,
  output logic      [atwst_pkg::DataW-1:0] prdata,
  output logic                             pready,
  output atwst_pkg::cfg_t                  cfg_o
);

  atwst_pkg::cfg_t     cfg_q, cfg_d;
  atwst_pkg::cfg_idx_e idx;
  logic                wr_en;

  assign idx    = atwst_pkg::cfg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        atwst_pkg::CfgStdGreen: cfg_d.std_green = pwdata[7:0];
        atwst_pkg::CfgMaxGreen: cfg_d.max_green = pwdata[7:0];
        atwst_pkg::CfgHighPct:  cfg_d.high_pct  = pwdata[6:0];
        atwst_pkg::CfgLowPct:   cfg_d.low_pct   = pwdata[6:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.std_green <= atwst_pkg::StdGreenRst;
      cfg_q.max_green <= atwst_pkg::MaxGreenRst;
      cfg_q.high_pct  <= atwst_pkg::HighPctRst;
      cfg_q.low_pct   <= atwst_pkg::LowPctRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      atwst_pkg::CfgStdGreen: prdata = {24'd0, cfg_q.std_green};
      atwst_pkg::CfgMaxGreen: prdata = {24'd0, cfg_q.max_green};
      atwst_pkg::CfgHighPct:  prdata = {25'd0, cfg_q.high_pct};
      atwst_pkg::CfgLowPct:   prdata = {25'd0, cfg_q.low_pct};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/atwst_adapt.sv
// Green length adaptation of the side whose phase is ending.
`default_nettype none

module atwst_adapt (
  input  wire logic [7:0]      queue_i,
  input  wire logic [7:0]      green_i,
  input  wire atwst_pkg::cfg_t cfg_i,
  output logic      [7:0]      green_o
);

  logic [atwst_pkg::LoadW-1:0]  load;
  logic [atwst_pkg::HiThrW-1:0] hi_thr;
  logic [8:0]                   stretched;
  logic [7:0]                   capped;
  logic [atwst_pkg::LoThrW-1:0] lo_thr_keep;
  logic [atwst_pkg::LoThrW-1:0] lo_thr_cap;
  logic                         do_stretch;
  logic [7:0]                   green_mid;
  logic [atwst_pkg::LoThrW-1:0] lo_thr;

  // Load and stretch threshold in parallel
  assign load   = atwst_pkg::LoadW'(queue_i) * atwst_pkg::LoadW'(atwst_pkg::LoadScale);
  assign hi_thr = (atwst_pkg::HiThrW'(cfg_i.high_pct) + atwst_pkg::HiThrW'(1))
                  * atwst_pkg::HiThrW'(green_i);
  assign do_stretch = atwst_pkg::HiThrW'(load) >= hi_thr;

  // Green plus half, capped at the ceiling
  assign stretched = {1'b0, green_i} + {2'b00, green_i[7:1]};
  assign capped    = (stretched > {1'b0, cfg_i.max_green}) ? cfg_i.max_green
                                                           : stretched[7:0];

  // Low threshold for both candidate greens, picked after the stretch test
  assign lo_thr_keep = atwst_pkg::LoThrW'(cfg_i.low_pct) * atwst_pkg::LoThrW'(green_i);
  assign lo_thr_cap  = atwst_pkg::LoThrW'(cfg_i.low_pct) * atwst_pkg::LoThrW'(capped);

  assign green_mid = do_stretch ? capped : green_i;
  assign lo_thr    = do_stretch ? lo_thr_cap : lo_thr_keep;
  assign green_o   = (load < lo_thr) ? cfg_i.std_green : green_mid;

endmodule

`default_nettype wire

// File: rtl/atwst_core.sv
// Tick pipeline: input register, timer state update and result register.
`default_nettype none
`include "adaptive_two_way_signal_timer_unit_defines.svh"

module atwst_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire atwst_pkg::cfg_t cfg_i,
  atwst_in_if.sink             item_in,
  atwst_out_if.source          result_out
);

  // Input stage
  logic in_vld_q;
  logic arr_a_q, arr_b_q;
  logic adv;

  // Timer state
  logic [7:0] qa_q, qb_q, qa_d, qb_d;
  logic [7:0] ga_q, gb_q, ga_d, gb_d;
  logic [7:0] ticks_q, ticks_d;
  logic       side_q, side_d;

  // Result stage
  logic       out_vld_q;
  logic       sw_q, sw_d;

  // Intermediate tick values
  logic [7:0] qa_arr, qb_arr;
  logic       expired;
  logic [7:0] serve_cnt, serve_g, g_new, ticks_load;

  assign adv           = in_vld_q && (!out_vld_q || result_out.ready);
  assign item_in.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in.valid && item_in.ready) begin
      arr_a_q <= item_in.arrive_a;
      arr_b_q <= item_in.arrive_b;
    end
  end

  // Arrivals saturate at the queue cap
  assign qa_arr = (arr_a_q && (qa_q < atwst_pkg::QueueCap)) ? qa_q + 8'd1 : qa_q;
  assign qb_arr = (arr_b_q && (qb_q < atwst_pkg::QueueCap)) ? qb_q + 8'd1 : qb_q;

  // Adapt the side whose green just ran out
  assign expired   = (ticks_q == 8'd0);
  assign serve_cnt = side_q ? qb_arr : qa_arr;
  assign serve_g   = side_q ? gb_q : ga_q;

  atwst_adapt u_adapt (
    .queue_i (serve_cnt),
    .green_i (serve_g),
    .cfg_i   (cfg_i),
    .green_o (g_new)
  );

  // Next state; the incoming side's green is never adapted on its switch tick
  always_comb begin
    ga_d       = (expired && !side_q) ? g_new : ga_q;
    gb_d       = (expired &&  side_q) ? g_new : gb_q;
    side_d     = side_q ^ expired;
    sw_d       = expired;
    ticks_load = expired ? (side_q ? ga_q : gb_q) : ticks_q;
    ticks_d    = (ticks_load != 8'd0) ? ticks_load - 8'd1 : 8'd0;
    qa_d       = (!side_d && (qa_arr != 8'd0)) ? qa_arr - 8'd1 : qa_arr;
    qb_d       = ( side_d && (qb_arr != 8'd0)) ? qb_arr - 8'd1 : qb_arr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q    <= 8'd0;
      qb_q    <= 8'd0;
      ga_q    <= atwst_pkg::StdGreenRst;
      gb_q    <= atwst_pkg::StdGreenRst;
      side_q  <= 1'b0;
      ticks_q <= atwst_pkg::StdGreenRst;
    end else if (adv) begin
      qa_q    <= qa_d;
      qb_q    <= qb_d;
      ga_q    <= ga_d;
      gb_q    <= gb_d;
      side_q  <= side_d;
      ticks_q <= ticks_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (result_out.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sw_q <= sw_d;
    end
  end

  // State registers hold exactly the last delivered values
  assign result_out.valid     = out_vld_q;
  assign result_out.side_now  = side_q;
  assign result_out.remaining = ticks_q;
  assign result_out.switched  = sw_q;
  assign result_out.queue_a   = qa_q;
  assign result_out.queue_b   = qb_q;
  assign result_out.green_a   = ga_q;
  assign result_out.green_b   = gb_q;

  // Checks
  `ATWST_NEVER(a_queue_cap, clk_i, rst_ni, (qa_q > atwst_pkg::QueueCap) || (qb_q > atwst_pkg::QueueCap), "queue above cap")
  `ATWST_ASSERT(a_side_hold, clk_i, rst_ni, (adv && !expired) |=> $stable(side_q), "side changed mid phase")
  `ATWST_ASSERT(a_side_flip, clk_i, rst_ni, (adv && expired) |=> (side_q != $past(side_q)), "side did not toggle")
  `ATWST_NEVER(a_no_overrun, clk_i, rst_ni, item_in.ready && in_vld_q && out_vld_q && !result_out.ready, "input taken while stalled")

endmodule

`default_nettype wire

// File: rtl/adaptive_two_way_signal_timer_unit.sv
// Top level of the adaptive two-way signal timer.
`default_nettype none

// Two-way signal timer advanced by one tick per arrival transfer. Each transfer
// carries the arrival bits of sides A and B and yields exactly one result
// transfer with the serving side, the countdown, the switch flag, both queue
// counts and both green lengths after that tick. The block takes one tick per
// clock cycle while the result side is not stalled; a tick passes the input
// register, then the timer state and result registers, which load together,
// and waits in the input register while the output is stalled. The rate is
// set by the update of the timer state (queues, countdown, side and green
// lengths), which feeds the next tick directly.
// Configuration (standard green, green ceiling, high and low load percent) is
// written over APB by the user only while no tick is in flight; the block does not enforce it.
module adaptive_two_way_signal_timer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [atwst_pkg::AddrW-1:0] paddr,
  input  wire logic [atwst_pkg::DataW-1:0] pwdata,
  output logic      [atwst_pkg::DataW-1:0] prdata,
  output logic                             pready,
  atwst_in_if.sink                         item_in,
  atwst_out_if.source                      result_out
);

  atwst_pkg::cfg_t cfg;

  atwst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  atwst_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_in    (item_in),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the adaptive two-way signal timer.

typedef enum bit {SideA = 1'b0, SideB = 1'b1} side_e;

// One result transfer as the block reports it
typedef struct packed {
  logic       side_now;
  logic [7:0] remaining;
  logic       switched;
  logic [7:0] queue_a;
  logic [7:0] queue_b;
  logic [7:0] green_a;
  logic [7:0] green_b;
} tick_result_t;

// Timer predictor plus the queue of results still owed by the block
class signal_timer_scoreboard;
  atwst_pkg::cfg_t cfg;
  logic [7:0]      wait_a, wait_b;
  logic [7:0]      green_a, green_b;
  logic [7:0]      countdown;
  side_e           side;
  tick_result_t    owed_results[$];
  int              mismatches;

  function new();
    cfg.std_green = atwst_pkg::StdGreenRst;
    cfg.max_green = atwst_pkg::MaxGreenRst;
    cfg.high_pct  = atwst_pkg::HighPctRst;
    cfg.low_pct   = atwst_pkg::LowPctRst;
    wait_a     = '0;
    wait_b     = '0;
    green_a    = cfg.std_green;
    green_b    = cfg.std_green;
    countdown  = cfg.std_green;
    side       = SideA;
    mismatches = 0;
  endfunction

  function void configure(atwst_pkg::cfg_idx_e idx, logic [31:0] value);
    case (idx)
      atwst_pkg::CfgStdGreen: cfg.std_green = value[7:0];
      atwst_pkg::CfgMaxGreen: cfg.max_green = value[7:0];
      atwst_pkg::CfgHighPct:  cfg.high_pct  = value[6:0];
      atwst_pkg::CfgLowPct:   cfg.low_pct   = value[6:0];
      default: ;
    endcase
  endfunction

  // Stretch on heavy load, then fall back to standard on light load
  function logic [7:0] adapted_green(logic [7:0] queue, logic [7:0] green);
    int unsigned load, hi_thr, lo_thr, stretched, g;
    g      = green;
    load   = atwst_pkg::LoadScale * queue;
    hi_thr = (int'(cfg.high_pct) + 1) * g;
    if (load >= hi_thr) begin
      stretched = g + (g >> 1);
      g = (stretched > cfg.max_green) ? cfg.max_green : stretched;
    end
    lo_thr = cfg.low_pct * g;
    if (load < lo_thr) g = cfg.std_green;
    return 8'(g);
  endfunction

  // Advance the timer by one tick and queue the result it owes
  function void advance_timer(bit arrive_a, bit arrive_b);
    tick_result_t res;
    res.switched = 1'b0;
    if (arrive_a && wait_a < atwst_pkg::QueueCap) wait_a++;
    if (arrive_b && wait_b < atwst_pkg::QueueCap) wait_b++;
    if (countdown == 0) begin
      if (side == SideA) green_a = adapted_green(wait_a, green_a);
      else green_b = adapted_green(wait_b, green_b);
      side = (side == SideA) ? SideB : SideA;
      countdown = (side == SideB) ? green_b : green_a;
      res.switched = 1'b1;
    end
    if (countdown != 0) countdown--;
    if (side == SideA) begin
      if (wait_a != 0) wait_a--;
    end else begin
      if (wait_b != 0) wait_b--;
    end
    res.side_now  = side;
    res.remaining = countdown;
    res.queue_a   = wait_a;
    res.queue_b   = wait_b;
    res.green_a   = green_a;
    res.green_b   = green_b;
    owed_results.insert(owed_results.size(), res);
  endfunction

  function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  function void check_result(tick_result_t got);
    tick_result_t exp_res;
    if (owed_results.size() == 0) begin
      $error("result transfer with no tick outstanding");
      mismatches++;
      return;
    end
    exp_res = owed_results.pop_front();
    compare_field("side_now", 8'(exp_res.side_now), 8'(got.side_now));
    compare_field("remaining", exp_res.remaining, got.remaining);
    compare_field("switched", 8'(exp_res.switched), 8'(got.switched));
    compare_field("queue_a", exp_res.queue_a, got.queue_a);
    compare_field("queue_b", exp_res.queue_b, got.queue_b);
    compare_field("green_a", exp_res.green_a, got.green_a);
    compare_field("green_b", exp_res.green_b, got.green_b);
  endfunction

  function int outstanding();
    return owed_results.size();
  endfunction
endclass

module tb;
  localparam int CycleLimit = 200000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [atwst_pkg::AddrW-1:0] paddr;
  logic [atwst_pkg::DataW-1:0] pwdata;
  logic [atwst_pkg::DataW-1:0] prdata;
  logic                        pready;

  atwst_in_if  item_if();
  atwst_out_if result_if();

  signal_timer_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  adaptive_two_way_signal_timer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .item_in    (item_if),
    .result_out (result_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side backpressure
  always @(negedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every result transfer
  always @(posedge clk_i) begin : result_monitor
    tick_result_t got;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got.side_now  = result_if.side_now;
      got.remaining = result_if.remaining;
      got.switched  = result_if.switched;
      got.queue_a   = result_if.queue_a;
      got.queue_b   = result_if.queue_b;
      got.green_a   = result_if.green_a;
      got.green_b   = result_if.green_b;
      sb.check_result(got);
    end
  end

  // One APB transfer; entered and left at a falling edge, bus left idle on return
  task automatic apb_access(input bit write, input atwst_pkg::cfg_idx_e idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write a register with junk above its width, then read it back
  task automatic program_register(atwst_pkg::cfg_idx_e idx, logic [7:0] value);
    logic [31:0] wdata, rdata, masked;
    wdata = $urandom();
    if (idx == atwst_pkg::CfgHighPct || idx == atwst_pkg::CfgLowPct) begin
      wdata[6:0] = value[6:0];
      masked = wdata & 32'h7F;
    end else begin
      wdata[7:0] = value;
      masked = wdata & 32'hFF;
    end
    apb_access(1'b1, idx, wdata, rdata);
    sb.configure(idx, wdata);
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== masked) begin
      $error("register %s: expected %0d, got %0d", idx.name(), masked, rdata);
      sb.mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  // Offer one tick, with random sender gaps, until it is transferred
  task automatic drive_tick(bit arrive_a, bit arrive_b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.arrive_a <= arrive_a;
    item_if.arrive_b <= arrive_b;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    sb.advance_timer(item_if.arrive_a, item_if.arrive_b);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(int count, int pct_a, int pct_b, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        item_if.valid <= 1'b0;
        @(negedge clk_i);
        wait_drained();
      end
      drive_tick($urandom_range(99) < pct_a, $urandom_range(99) < pct_b);
    end
    item_if.valid <= 1'b0;
  endtask

  // Reconfigure while idle, then run a burst of random ticks
  task automatic run_phase(logic [7:0] std_g, logic [7:0] max_g, logic [6:0] hi,
                           logic [6:0] lo, int idle, int stall, int pct_a, int pct_b,
                           int count, int pause_at);
    wait_drained();
    repeat (4) @(negedge clk_i);
    program_register(atwst_pkg::CfgStdGreen, std_g);
    program_register(atwst_pkg::CfgMaxGreen, max_g);
    program_register(atwst_pkg::CfgHighPct, {1'b0, hi});
    program_register(atwst_pkg::CfgLowPct, {1'b0, lo});
    send_idle_pct = idle;
    stall_pct    <= stall;
    send_ticks(count, pct_a, pct_b, pause_at);
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    item_if.valid    = 1'b0;
    item_if.arrive_a = 1'b0;
    item_if.arrive_b = 1'b0;
    result_if.ready  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: all arrival combinations, then steady load through the first switch
    drive_tick(1'b0, 1'b0);
    drive_tick(1'b1, 1'b0);
    drive_tick(1'b0, 1'b1);
    drive_tick(1'b1, 1'b1);
    for (int i = 0; i < 20; i++) drive_tick(1'b1, 1'b1);
    item_if.valid <= 1'b0;

    // Reset values, no idling, one mid-phase drain
    run_phase(8'd20, 8'd255, 7'd70, 7'd50, 0, 0, 50, 50, 200, 100);
    // Shortest green, lowest stretch threshold, never fall back
    run_phase(8'd1, 8'd255, 7'd0, 7'd0, 55, 0, 90, 90, 200, -1);
    // Long standard green, ceiling below current greens
    run_phase(8'd255, 8'd1, 7'd100, 7'd100, 0, 55, 30, 30, 200, -1);
    // Zero standard green and thresholds above 100 on light traffic
    run_phase(8'd0, 8'd255, 7'd127, 7'd127, 11, 11, 10, 10, 150, -1);
    // Flood both sides to reach the queue ceiling
    run_phase(8'd200, 8'd255, 7'd10, 7'd5, 0, 0, 100, 100, 500, -1);
    // Random settings
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              55, 0, $urandom_range(0, 100), $urandom_range(0, 100), 150, -1);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              0, 55, $urandom_range(0, 100), $urandom_range(0, 100), 150, -1);
    run_phase(8'd20, 8'd255, 7'd70, 7'd50, 11, 11, 50, 50, 100, -1);

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
